[hdl/rdc_pkg.sv]
package rdc_pkg;

    // Field widths fixed by the stream formats
    localparam int CP_W       = 21;
    localparam int DIGIT_W    = 6;
    localparam int RADIX_W    = 6;
    localparam int STYLE_W    = 2;
    localparam int GROUP_W    = 6;
    localparam int MAG_W      = 64;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;

    // Remainder unit retires this many dividend bits per cycle
    localparam int DIV_BITS_PER_CYCLE = 8;

    // Configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_PLAIN_GROUP = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BASED_GROUP = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PLAIN_SEP   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_BASED_SEP   = 2'd3;

    localparam logic [GROUP_W-1:0] PLAIN_GROUP_RST = 6'd3;
    localparam logic [GROUP_W-1:0] BASED_GROUP_RST = 6'd4;
    localparam logic [CP_W-1:0]    SEP_RST         = 21'd8239;

    // Radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    // Digit styles
    localparam logic [STYLE_W-1:0] STYLE_PLAIN = 2'd0;
    localparam logic [STYLE_W-1:0] STYLE_SUPER = 2'd1;
    localparam logic [STYLE_W-1:0] STYLE_SUB   = 2'd2;

    // Digit values with their own superscript glyphs, and the first letter digit
    localparam logic [DIGIT_W-1:0] DIGIT_ZERO  = 6'd0;
    localparam logic [DIGIT_W-1:0] DIGIT_ONE   = 6'd1;
    localparam logic [DIGIT_W-1:0] DIGIT_TWO   = 6'd2;
    localparam logic [DIGIT_W-1:0] DIGIT_THREE = 6'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;

    // Code points
    localparam logic [CP_W-1:0] CP_ASCII_ZERO  = 21'h000030;
    localparam logic [CP_W-1:0] CP_LETTER_BIAS = 21'h000037;  // 'A' - 10
    localparam logic [CP_W-1:0] CP_SUP_ZERO    = 21'h002070;
    localparam logic [CP_W-1:0] CP_SUP_ONE     = 21'h0000B9;
    localparam logic [CP_W-1:0] CP_SUP_TWO     = 21'h0000B2;
    localparam logic [CP_W-1:0] CP_SUP_THREE   = 21'h0000B3;
    localparam logic [CP_W-1:0] CP_SUB_ZERO    = 21'h002080;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_CHECK = 5'b00100,
        S_READ  = 5'b01000,
        S_LOAD  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic start_emit;
        logic out_load;
        logic dec_k;
    } t_cmd;

    typedef struct packed {
        logic chunk_last;
        logic quot_zero;
        logic count_full;
        logic k_zero;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [GROUP_W-1:0] plain_group;
        logic [GROUP_W-1:0] based_group;
        logic [CP_W-1:0]    plain_sep;
        logic [CP_W-1:0]    based_sep;
    } t_cfg;

    // Digit value to code point; values of ten and up are letters in any style
    function automatic logic [CP_W-1:0] digit_code(input logic [DIGIT_W-1:0] d,
                                                   input logic [STYLE_W-1:0] style);
        logic [CP_W-1:0] dx;
        dx = {{(CP_W-DIGIT_W){1'b0}}, d};
        if (d >= DIGIT_TEN) begin
            digit_code = dx + CP_LETTER_BIAS;
        end else begin
            case (style)
                STYLE_SUPER: begin
                    case (d)
                        DIGIT_ZERO:  digit_code = CP_SUP_ZERO;
                        DIGIT_ONE:   digit_code = CP_SUP_ONE;
                        DIGIT_TWO:   digit_code = CP_SUP_TWO;
                        DIGIT_THREE: digit_code = CP_SUP_THREE;
                        default:     digit_code = CP_SUP_ZERO + dx;
                    endcase
                end
                STYLE_SUB: digit_code = CP_SUB_ZERO + dx;
                default:   digit_code = CP_ASCII_ZERO + dx;
            endcase
        end
    endfunction

endpackage

[hdl/rdc_regs.sv]
module rdc_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rdc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rdc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rdc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output rdc_pkg::t_cfg                   o_cfg
);
    import rdc_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.plain_group <= PLAIN_GROUP_RST;
            r_cfg.based_group <= BASED_GROUP_RST;
            r_cfg.plain_sep   <= SEP_RST;
            r_cfg.based_sep   <= SEP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PLAIN_GROUP: r_cfg.plain_group <= pwdata[GROUP_W-1:0];
                REG_BASED_GROUP: r_cfg.based_group <= pwdata[GROUP_W-1:0];
                REG_PLAIN_SEP:   r_cfg.plain_sep   <= pwdata[CP_W-1:0];
                REG_BASED_SEP:   r_cfg.based_sep   <= pwdata[CP_W-1:0];
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_PLAIN_GROUP: prdata = {{(CFG_DATA_W-GROUP_W){1'b0}}, r_cfg.plain_group};
            REG_BASED_GROUP: prdata = {{(CFG_DATA_W-GROUP_W){1'b0}}, r_cfg.based_group};
            REG_PLAIN_SEP:   prdata = {{(CFG_DATA_W-CP_W){1'b0}}, r_cfg.plain_sep};
            REG_BASED_SEP:   prdata = {{(CFG_DATA_W-CP_W){1'b0}}, r_cfg.based_sep};
        endcase
    end

endmodule

[hdl/rdc_ctrl.sv]
module rdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rdc_pkg::t_status i_status,
    output rdc_pkg::t_cmd    o_cmd
);
    import rdc_pkg::*;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Sequencer: divide digit by digit, then read digits back in reverse
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.chunk_last) begin
                    o_cmd.store = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.quot_zero || i_status.count_full) begin
                    o_cmd.start_emit = 1'b1;
                    n_state          = S_READ;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_status.k_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.dec_k = 1'b1;
                        n_state     = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/rdc_dp.sv]
module rdc_dp #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rdc_pkg::t_cfg                 i_cfg,
    input  rdc_pkg::t_cmd                 i_cmd,
    output rdc_pkg::t_status              o_status,
    input  logic [rdc_pkg::MAG_W-1:0]     i_magnitude,
    input  logic [rdc_pkg::RADIX_W-1:0]   i_radix,
    input  logic [rdc_pkg::STYLE_W-1:0]   i_style,
    input  logic                          i_based,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [rdc_pkg::CP_W-1:0]      o_code_point,
    output logic                          o_sep_before,
    output logic [rdc_pkg::CP_W-1:0]      o_sep_code,
    output logic                          o_last
);
    import rdc_pkg::*;

    localparam int STEP    = DIV_BITS_PER_CYCLE;
    localparam int CHUNKS  = (VALUE_BITS + STEP - 1) / STEP;
    localparam int PAD_W   = CHUNKS * STEP;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int COUNT_W = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W  = $clog2(MAX_DIGITS);
    localparam int ENTRY_W = DIGIT_W + 1;

    // Working value: dividend bits leave at the top, quotient bits enter at the bottom
    logic [PAD_W-1:0]   r_value;
    logic [DIGIT_W-1:0] r_rem;
    logic [RADIX_W-1:0] r_radix;
    logic [STYLE_W-1:0] r_style;
    logic [GROUP_W-1:0] r_spacing;
    logic [CP_W-1:0]    r_sep_sel;
    logic [CHUNK_W-1:0] r_chunk;
    logic [COUNT_W-1:0] r_count;
    logic [GROUP_W-1:0] r_phase;
    logic [ADDR_W-1:0]  r_k;
    logic [ADDR_W-1:0]  r_last_k;

    // Digit store: remainder plus group-end flag per digit
    logic [ENTRY_W-1:0] r_mem [0:MAX_DIGITS-1];
    logic [ENTRY_W-1:0] r_rd;

    logic               r_out_valid;
    logic [CP_W-1:0]    r_cp;
    logic               r_sep;
    logic [CP_W-1:0]    r_sep_code;
    logic               r_last;

    logic [RADIX_W-1:0] radix_clamped;
    logic [STEP-1:0]    q_bits;
    logic [DIGIT_W-1:0] n_rem;
    logic [DIGIT_W:0]   trial;
    logic [PAD_W-1:0]   n_value;
    logic               group_end;
    logic               out_sep;
    logic [GROUP_W-1:0] sel_spacing;

    always_comb begin
        if (i_radix < RADIX_MIN) begin
            radix_clamped = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            radix_clamped = RADIX_MAX;
        end else begin
            radix_clamped = i_radix;
        end
    end

    assign sel_spacing = i_based ? i_cfg.based_group : i_cfg.plain_group;

    // Remainder unit: STEP restoring steps per cycle on a narrow remainder
    always_comb begin
        n_rem  = r_rem;
        q_bits = '0;
        trial  = '0;
        for (int j = 0; j < STEP; j++) begin
            trial = {n_rem, r_value[PAD_W-1-j]};
            if (trial >= {1'b0, r_radix}) begin
                q_bits[STEP-1-j] = 1'b1;
                n_rem            = DIGIT_W'(trial - {1'b0, r_radix});
            end else begin
                n_rem = trial[DIGIT_W-1:0];
            end
        end
        n_value = (r_value << STEP) | PAD_W'(q_bits);
    end

    assign group_end = (r_spacing != '0) && (r_phase == r_spacing);
    assign out_sep   = r_rd[DIGIT_W] && (r_k != r_last_k);

    assign o_status.chunk_last = (r_chunk == CHUNK_W'(CHUNKS - 1));
    assign o_status.quot_zero  = (r_value == '0);
    assign o_status.count_full = (r_count == COUNT_W'(MAX_DIGITS));
    assign o_status.k_zero     = (r_k == '0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // Per-item setup and division bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value   <= PAD_W'(i_magnitude[VALUE_BITS-1:0]);
            r_rem     <= '0;
            r_radix   <= radix_clamped;
            r_style   <= i_style;
            r_spacing <= sel_spacing;
            r_sep_sel <= i_based ? i_cfg.based_sep : i_cfg.plain_sep;
            r_chunk   <= '0;
            r_count   <= '0;
            r_phase   <= GROUP_W'(1);
        end else if (i_cmd.div_step) begin
            r_value <= n_value;
            if (i_cmd.store) begin
                r_rem   <= '0;
                r_chunk <= '0;
                r_count <= r_count + 1'b1;
                r_phase <= group_end ? GROUP_W'(1) : r_phase + 1'b1;
            end else begin
                r_rem   <= n_rem;
                r_chunk <= r_chunk + 1'b1;
            end
        end
    end

    // Readback index, most significant digit first
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_emit) begin
            r_k      <= ADDR_W'(r_count - 1'b1);
            r_last_k <= ADDR_W'(r_count - 1'b1);
        end else if (i_cmd.dec_k) begin
            r_k <= r_k - 1'b1;
        end
    end

    // Digit store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_count[ADDR_W-1:0]] <= {group_end, n_rem};
        end
        r_rd <= r_mem[r_k];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_cp       <= digit_code(r_rd[DIGIT_W-1:0], r_style);
            r_sep      <= out_sep;
            r_sep_code <= out_sep ? r_sep_sel : '0;
            r_last     <= (r_k == '0);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_cp;
    assign o_sep_before = r_sep;
    assign o_sep_code   = r_sep_code;
    assign o_last       = r_last;

endmodule

[hdl/radix_digit_converter.sv]
// Channel   Dir  Beat                 tdata (low bit up)                        tuser / tlast
// s_axis    in   one value            magnitude[63:0] radix[69:64] style[71:70] tuser=is_based
// m_axis    out  one digit            code_point[20:0] separator_code[41:21]    tuser=separator_before
//                                     zero pad[47:42]                           tlast=last_digit
// apb       in   register access      plain_group 0x0, based_group 0x4, plain_sep 0x8, based_sep 0xC
//
// Each digit takes a full pass of the remainder unit over the padded value (8 dividend bits per
// cycle) and a check of the quotient; digits are then read back from the digit store and loaded
// into the output register one at a time.
// Synchronous active-low reset; the digit store needs no clearing pass after reset.
// s_axis is taken only between values; a stalled m_axis holds the sequencer in readback.
module radix_digit_converter #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // magnitude, radix, digit_style
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [rdc_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // is_based
    input  logic                            i_s_tuser,
    // code_point, separator_code
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [rdc_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // separator_before
    output logic                            o_m_tuser,
    output logic                            o_m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rdc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rdc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rdc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import rdc_pkg::*;

    t_cfg            cfg;
    t_cmd            cmd;
    t_status         status;
    logic [CP_W-1:0] code_point;
    logic [CP_W-1:0] sep_code;

    rdc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rdc_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_magnitude  (i_s_tdata[MAG_W-1:0]),
        .i_radix      (i_s_tdata[MAG_W+RADIX_W-1:MAG_W]),
        .i_style      (i_s_tdata[MAG_W+RADIX_W+STYLE_W-1:MAG_W+RADIX_W]),
        .i_based      (i_s_tuser),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_code_point (code_point),
        .o_sep_before (o_m_tuser),
        .o_sep_code   (sep_code),
        .o_last       (o_m_tlast)
    );

    assign o_m_tdata = {{(OUT_DATA_W-2*CP_W){1'b0}}, sep_code, code_point};

endmodule

[hdl/rdc_checker.sv]
module rdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);

    // A stalled digit beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output beat changed while stalled");

    // A value is converted before the next one is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while a value is in progress");

    // Separator code reads zero unless a separator precedes the digit
    a_sep_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[41:21] == 21'd0)
        else $error("separator code set without separator");

    // Pad bits above the separator code stay clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[47:42] == 6'd0)
        else $error("output pad bits set");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
